// ===== design/fpra_pkg.sv =====
// ----------------------------------------------------------------------------
// fpra_pkg
// shared types, status codes and request codes of the free page range allocator
// ----------------------------------------------------------------------------
package fpra_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [31:0] PAGE_NONE = 32'hFFFF_FFFF;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_NOFIT   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] start_page;
        logic [31:0] num_pages;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] alloc_start;
        logic        removed_any;
    } t_rsp;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_range;

    typedef struct packed {
        logic        eq;
        logic        fits;
        logic        better;
        logic        overlap;
        logic        has_left;
        logic        has_right;
        logic [31:0] left_len;
        logic [31:0] right_start;
        logic [31:0] right_len;
    } t_unit_res;

endpackage

// ===== design/free_page_range_allocator.sv =====
// ----------------------------------------------------------------------------
// free_page_range_allocator
// best fit free page range table with add, allocate and remove requests
// ----------------------------------------------------------------------------
// add: one table scan for a duplicate and the lowest free slot, then the write
// allocate: one table scan, a second scan for the remainder match check
// remove: scan plus a match search over the piece buffer per piece, then a copy
//   back into the table; all steps share the single compare unit
// one request at a time; reset clears all valid bits at once, table memory is not swept
module free_page_range_allocator
    import fpra_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int PAW = $clog2(2 * TABLE_ENTRIES);
    localparam int PW  = $clog2(2 * TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);
    localparam logic [PW-1:0] NUM_SLOTS = PW'(TABLE_ENTRIES);
    localparam logic [PW-1:0] MAX_PCS   = PW'(2 * TABLE_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD      = 4'd1;
    localparam logic [3:0] S_ADD_END  = 4'd2;
    localparam logic [3:0] S_AL_SCAN  = 4'd3;
    localparam logic [3:0] S_AL_END   = 4'd4;
    localparam logic [3:0] S_AL_DUP   = 4'd5;
    localparam logic [3:0] S_AL_WB    = 4'd6;
    localparam logic [3:0] S_RM_SCAN  = 4'd7;
    localparam logic [3:0] S_RM_PIECE = 4'd8;
    localparam logic [3:0] S_RM_END   = 4'd9;
    localparam logic [3:0] S_RM_COPY  = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    // control state
    logic [3:0]               r_state, n_state;
    logic                     r_ph, n_ph;
    logic [IW-1:0]            r_idx, n_idx;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [PW-1:0]            r_pn, n_pn;
    logic [PW-1:0]            r_pk, n_pk;
    logic                     r_ov, n_ov;

    // request and scratch payload
    logic [31:0]   r_s, n_s;
    logic [31:0]   r_l, n_l;
    logic          r_dup, n_dup;
    logic          r_free_ok, n_free_ok;
    logic [IW-1:0] r_free, n_free;
    logic          r_have, n_have;
    logic [IW-1:0] r_best, n_best;
    logic [31:0]   r_bs, n_bs;
    logic [31:0]   r_bl, n_bl;
    logic [31:0]   r_rest_s, n_rest_s;
    logic [31:0]   r_rest_l, n_rest_l;
    logic          r_hit, n_hit;
    logic          r_c0v, n_c0v;
    t_range        r_c0, n_c0;
    logic          r_c1v, n_c1v;
    t_range        r_c1, n_c1;
    t_rsp          r_res, n_res;
    t_rsp          r_out, n_out;

    // range table and piece buffer
    t_range r_tmem [TABLE_ENTRIES];
    t_range r_trd;
    logic            t_we;
    logic [IW-1:0]   t_waddr;
    t_range          t_wdata;

    t_range r_pmem [2 * TABLE_ENTRIES];
    t_range r_prd;
    logic            p_we;
    logic [PAW-1:0]  p_waddr;
    t_range          p_wdata;
    logic [PAW-1:0]  p_raddr;

    // shared compare unit
    t_range    u_entry;
    t_range    u_key;
    t_range    u_best;
    t_unit_res u_res;
    t_range    cand;
    logic [32:0] rest_end;

    fpra_unit u_unit (
        .i_entry     (u_entry),
        .i_key       (u_key),
        .i_best      (u_best),
        .i_have_best (r_have),
        .o_res       (u_res)
    );

    assign cand     = r_c0v ? r_c0 : r_c1;
    assign u_best   = '{start: r_bs, len: r_bl};
    assign u_entry  = (r_state == S_RM_PIECE) ? r_prd : r_trd;
    assign rest_end = {1'b0, r_bs} + {1'b0, r_l};
    assign p_raddr  = (r_state == S_RM_COPY) ? PAW'(r_idx) : r_pk[PAW-1:0];

    always_comb begin
        case (r_state)
            S_AL_DUP:   u_key = '{start: r_rest_s, len: r_rest_l};
            S_RM_PIECE: u_key = cand;
            default:    u_key = '{start: r_s, len: r_l};
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_ph      = r_ph;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_pn      = r_pn;
        n_pk      = r_pk;
        n_ov      = r_ov;
        n_s       = r_s;
        n_l       = r_l;
        n_dup     = r_dup;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_have    = r_have;
        n_best    = r_best;
        n_bs      = r_bs;
        n_bl      = r_bl;
        n_rest_s  = r_rest_s;
        n_rest_l  = r_rest_l;
        n_hit     = r_hit;
        n_c0v     = r_c0v;
        n_c0      = r_c0;
        n_c1v     = r_c1v;
        n_c1      = r_c1;
        n_res     = r_res;
        n_out     = r_out;
        t_we      = 1'b0;
        t_waddr   = r_idx;
        t_wdata   = '{start: r_s, len: r_l};
        p_we      = 1'b0;
        p_waddr   = r_pn[PAW-1:0];
        p_wdata   = cand;

        // output register drains independently of the sequencer
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_s       = i_in_data.start_page;
                    n_l       = i_in_data.num_pages;
                    n_idx     = '0;
                    n_ph      = 1'b0;
                    n_dup     = 1'b0;
                    n_free_ok = 1'b0;
                    n_have    = 1'b0;
                    n_hit     = 1'b0;
                    n_pn      = '0;
                    n_res     = '{status: ST_OK, alloc_start: 32'd0, removed_any: 1'b0};
                    case (i_in_data.req_type)
                        REQ_ADD: begin
                            if (i_in_data.num_pages == 32'd0) begin
                                n_res.status = ST_INVALID;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        REQ_ALLOC: begin
                            if (i_in_data.num_pages == 32'd0) begin
                                n_res.status = ST_NOFIT;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_AL_SCAN;
                            end
                        end
                        REQ_REMOVE: begin
                            if (i_in_data.start_page == PAGE_NONE ||
                                i_in_data.num_pages == 32'd0) begin
                                n_res.status = ST_INVALID;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_RM_SCAN;
                            end
                        end
                        default: begin
                            n_res.status = ST_INVALID;
                            n_state      = S_FIN;
                        end
                    endcase
                end
            end

            // duplicate search and lowest free slot
            S_ADD: begin
                if (!r_ph && !r_valid[r_idx]) begin
                    if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    if (r_idx == LAST_IDX) n_state = S_ADD_END;
                    else                   n_idx   = r_idx + 1'b1;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (u_res.eq) n_dup = 1'b1;
                    if (r_idx == LAST_IDX) n_state = S_ADD_END;
                    else                   n_idx   = r_idx + 1'b1;
                end
            end

            S_ADD_END: begin
                n_state = S_FIN;
                if (r_dup) begin
                    n_res.status = ST_DUP;
                end else if (!r_free_ok) begin
                    n_res.status = ST_FULL;
                end else begin
                    t_we             = 1'b1;
                    t_waddr          = r_free;
                    n_valid[r_free]  = 1'b1;
                end
            end

            // best fit search
            S_AL_SCAN: begin
                if (!r_ph && !r_valid[r_idx]) begin
                    if (r_idx == LAST_IDX) n_state = S_AL_END;
                    else                   n_idx   = r_idx + 1'b1;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (u_res.fits && u_res.better) begin
                        n_have = 1'b1;
                        n_best = r_idx;
                        n_bs   = r_trd.start;
                        n_bl   = r_trd.len;
                    end
                    if (r_idx == LAST_IDX) n_state = S_AL_END;
                    else                   n_idx   = r_idx + 1'b1;
                end
            end

            S_AL_END: begin
                if (!r_have) begin
                    n_res.status = ST_NOFIT;
                    n_state      = S_FIN;
                end else begin
                    n_res.alloc_start = r_bs;
                    if ((r_l < r_bl) && !rest_end[32]) begin
                        n_rest_s = rest_end[31:0];
                        n_rest_l = r_bl - r_l;
                        n_idx    = '0;
                        n_ph     = 1'b0;
                        n_dup    = 1'b0;
                        n_state  = S_AL_DUP;
                    end else begin
                        n_valid[r_best] = 1'b0;
                        n_state         = S_FIN;
                    end
                end
            end

            // remainder must not match any other entry
            S_AL_DUP: begin
                if (!r_ph && (!r_valid[r_idx] || r_idx == r_best)) begin
                    if (r_idx == LAST_IDX) n_state = S_AL_WB;
                    else                   n_idx   = r_idx + 1'b1;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (u_res.eq) n_dup = 1'b1;
                    if (r_idx == LAST_IDX) n_state = S_AL_WB;
                    else                   n_idx   = r_idx + 1'b1;
                end
            end

            S_AL_WB: begin
                n_state = S_FIN;
                if (r_dup) begin
                    n_valid[r_best] = 1'b0;
                end else begin
                    t_we    = 1'b1;
                    t_waddr = r_best;
                    t_wdata = '{start: r_rest_s, len: r_rest_l};
                end
            end

            // split each stored range into up to two pieces
            S_RM_SCAN: begin
                if (!r_ph && !r_valid[r_idx]) begin
                    if (r_idx == LAST_IDX) n_state = S_RM_END;
                    else                   n_idx   = r_idx + 1'b1;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph    = 1'b0;
                    n_pk    = '0;
                    n_state = S_RM_PIECE;
                    if (!u_res.overlap) begin
                        n_c0v = r_trd.len != 32'd0;
                        n_c0  = r_trd;
                        n_c1v = 1'b0;
                    end else begin
                        n_hit = 1'b1;
                        n_c0v = u_res.has_left;
                        n_c0  = '{start: r_trd.start, len: u_res.left_len};
                        n_c1v = u_res.has_right;
                        n_c1  = '{start: u_res.right_start, len: u_res.right_len};
                    end
                end
            end

            // match search of the current piece against kept pieces, then append
            S_RM_PIECE: begin
                if (!r_c0v && !r_c1v) begin
                    n_ph = 1'b0;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_RM_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RM_SCAN;
                    end
                end else if (!r_ph && r_pk == r_pn) begin
                    p_we = 1'b1;
                    n_pn = r_pn + 1'b1;
                    n_pk = '0;
                    if (r_c0v) n_c0v = 1'b0;
                    else       n_c1v = 1'b0;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (u_res.eq) begin
                        n_pk = '0;
                        if (r_c0v) n_c0v = 1'b0;
                        else       n_c1v = 1'b0;
                    end else begin
                        n_pk = r_pk + 1'b1;
                    end
                end
            end

            S_RM_END: begin
                if (!r_hit) begin
                    n_state = S_FIN;
                end else if (r_pn > NUM_SLOTS) begin
                    n_res.status = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_idx   = '0;
                    n_ph    = 1'b0;
                    n_state = S_RM_COPY;
                end
            end

            // pack kept pieces into the lowest slots
            S_RM_COPY: begin
                if (!r_ph && PW'(r_idx) < r_pn) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_ph) begin
                        t_we           = 1'b1;
                        t_wdata        = r_prd;
                        n_valid[r_idx] = 1'b1;
                    end else begin
                        n_valid[r_idx] = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_res.removed_any = 1'b1;
                        n_state           = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_idx   <= '0;
            r_valid <= '0;
            r_pn    <= '0;
            r_pk    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_pn    <= n_pn;
            r_pk    <= n_pk;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_l       <= n_l;
        r_dup     <= n_dup;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_have    <= n_have;
        r_best    <= n_best;
        r_bs      <= n_bs;
        r_bl      <= n_bl;
        r_rest_s  <= n_rest_s;
        r_rest_l  <= n_rest_l;
        r_hit     <= n_hit;
        r_c0v     <= n_c0v;
        r_c0      <= n_c0;
        r_c1v     <= n_c1v;
        r_c1      <= n_c1;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= t_wdata;
        end
        r_trd <= r_tmem[r_idx];
    end

    // piece buffer memory
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[p_waddr] <= p_wdata;
        end
        r_prd <= r_pmem[p_raddr];
    end

    // piece count stays within the buffer
    a_pn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pn <= MAX_PCS)
        else $error("piece count beyond buffer");

    // a finished result reaches a free output register in the next cycle
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_ov) |=> r_ov)
        else $error("result not transferred to output");

    // removed pages only reported on success
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.removed_any) |-> (o_out_data.status == ST_OK))
        else $error("removed flag with error status");

    // allocate start only reported on success
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.alloc_start != 32'd0) |-> (o_out_data.status == ST_OK))
        else $error("alloc start with error status");

endmodule

// ===== design/fpra_unit.sv =====
// ----------------------------------------------------------------------------
// fpra_unit
// shared range compare unit: match, best fit test and overlap split
// ----------------------------------------------------------------------------
module fpra_unit
    import fpra_pkg::*;
(
    input  t_range    i_entry,
    input  t_range    i_key,
    input  t_range    i_best,
    input  logic      i_have_best,
    output t_unit_res o_res
);

    logic [32:0] entry_end;
    logic [32:0] key_end;

    assign entry_end = {1'b0, i_entry.start} + {1'b0, i_entry.len};
    assign key_end   = {1'b0, i_key.start} + {1'b0, i_key.len};

    always_comb begin
        o_res.eq     = (i_entry.start == i_key.start) && (i_entry.len == i_key.len);
        o_res.fits   = i_entry.len >= i_key.len;
        o_res.better = !i_have_best || (i_entry.len < i_best.len) ||
                       ((i_entry.len == i_best.len) && (i_entry.start < i_best.start));
        // entries with zero length or an all-ones start never overlap
        o_res.overlap = (i_entry.len != 32'd0) && (i_entry.start != PAGE_NONE) &&
                        ({1'b0, i_entry.start} < key_end) &&
                        ({1'b0, i_key.start} < entry_end);
        o_res.has_left    = i_entry.start < i_key.start;
        o_res.left_len    = i_key.start - i_entry.start;
        o_res.has_right   = (key_end < entry_end) && !key_end[32];
        o_res.right_start = key_end[31:0];
        o_res.right_len   = entry_end[31:0] - key_end[31:0];
    end

endmodule

// ===== bench/tb_free_page_range_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_free_page_range_allocator
// self-checking bench for the best fit free page range table
// ----------------------------------------------------------------------------
// a short table of directed requests covers the edge cases, then random
// traffic keeps the table small and busy, with phases that fill it to the
// top, split ranges against a full table and wipe it again. every transfer
// on the output is checked against a local copy of the range table.
module tb_free_page_range_allocator;
    import fpra_pkg::*;

    localparam int ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int NUM_RANDOM  = 1930;
    localparam int CYCLE_LIMIT = 200_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int RSP_DEPTH   = 64;
    localparam int DIR_DEPTH   = 32;
    localparam logic [1:0] REQ_BAD = 2'd3;   // request code the block does not know

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;

    free_page_range_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // local copy of the free range table
    // ------------------------------------------------------------------
    logic        free_vld[ENTRIES];
    logic [31:0] free_start[ENTRIES];
    logic [31:0] free_len[ENTRIES];
    int          free_cnt;

    // pieces collected while a remove walks the table
    logic [31:0] piece_start[2*ENTRIES];
    logic [31:0] piece_len[2*ENTRIES];
    int          piece_cnt;

    // responses still owed by the block, ring indexed by running counts
    t_rsp rsp_mem[RSP_DEPTH];
    int   rsp_wr, rsp_rd;
    int   err_cnt;
    int   req_cnt[4];
    int   full_cnt, fit_cnt, removed_cnt;
    int   hold_req;      // bumped by the sender to ask for a long output hold-off

    function automatic logic is_dup(logic [31:0] s, logic [31:0] l, int skip);
        for (int i = 0; i < ENTRIES; i++)
            if (i != skip && free_vld[i] && free_start[i] == s && free_len[i] == l)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void keep_piece(logic [32:0] s, logic [32:0] l);
        if (l == 0 || s[32])
            return;
        for (int k = 0; k < piece_cnt; k++)
            if (piece_start[k] == s[31:0] && piece_len[k] == l[31:0])
                return;
        if (piece_cnt < 2*ENTRIES) begin
            piece_start[piece_cnt] = s[31:0];
            piece_len[piece_cnt]   = l[31:0];
            piece_cnt++;
        end
    endfunction

    // applies one request to the local table and returns the response it owes
    function automatic t_rsp apply_request(t_req r);
        t_rsp        res;
        int          best;
        logic        hit;
        logic [32:0] rest, xe, e;
        res = '0;
        best = -1;
        hit = 1'b0;
        case (r.req_type)
            REQ_ADD: begin
                if (r.num_pages == 0) begin
                    res.status = ST_INVALID;
                end else if (is_dup(r.start_page, r.num_pages, -1)) begin
                    res.status = ST_DUP;
                end else begin
                    res.status = ST_FULL;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!free_vld[i]) begin
                            free_vld[i] = 1'b1;
                            free_start[i] = r.start_page;
                            free_len[i] = r.num_pages;
                            free_cnt++;
                            res.status = ST_OK;
                            break;
                        end
                end
            end
            REQ_ALLOC: begin
                res.status = ST_NOFIT;
                if (r.num_pages != 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!free_vld[i] || free_len[i] < r.num_pages)
                            continue;
                        if (best < 0 || free_len[i] < free_len[best] ||
                            (free_len[i] == free_len[best] &&
                             free_start[i] < free_start[best]))
                            best = i;
                    end
                    if (best >= 0) begin
                        res.status = ST_OK;
                        res.alloc_start = free_start[best];
                        rest = {1'b0, free_start[best]} + r.num_pages;
                        // front goes out, remainder stays in the slot unless it
                        // runs past the page space or copies another entry
                        if (r.num_pages < free_len[best] && !rest[32] &&
                            !is_dup(rest[31:0], free_len[best] - r.num_pages, best)) begin
                            free_len[best] = free_len[best] - r.num_pages;
                            free_start[best] = rest[31:0];
                        end else begin
                            free_vld[best] = 1'b0;
                            free_start[best] = '0;
                            free_len[best] = '0;
                            free_cnt--;
                        end
                    end
                end
            end
            REQ_REMOVE: begin
                if (r.start_page == PAGE_NONE || r.num_pages == 0) begin
                    res.status = ST_INVALID;
                end else begin
                    res.status = ST_OK;
                    xe = {1'b0, r.start_page} + r.num_pages;
                    piece_cnt = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!free_vld[i])
                            continue;
                        e = {1'b0, free_start[i]} + free_len[i];
                        if (free_len[i] == 0 || free_start[i] == PAGE_NONE ||
                            !({1'b0, free_start[i]} < xe && {1'b0, r.start_page} < e)) begin
                            keep_piece({1'b0, free_start[i]}, {1'b0, free_len[i]});
                            continue;
                        end
                        hit = 1'b1;
                        if (free_start[i] < r.start_page)
                            keep_piece({1'b0, free_start[i]},
                                       {1'b0, r.start_page} - free_start[i]);
                        if (xe < e)
                            keep_piece(xe, e - xe);
                    end
                    if (hit && piece_cnt > ENTRIES) begin
                        res.status = ST_FULL;
                    end else if (hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            free_vld[i]   = i < piece_cnt;
                            free_start[i] = i < piece_cnt ? piece_start[i] : '0;
                            free_len[i]   = i < piece_cnt ? piece_len[i] : '0;
                        end
                        free_cnt = piece_cnt;
                        res.removed_any = 1'b1;
                    end
                end
            end
            default: res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // directed table: expected response typed in where known, else predicted
    // ------------------------------------------------------------------
    typedef struct {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_dir_row;

    t_dir_row dir_tab[DIR_DEPTH];
    int       dir_cnt;

    function automatic void row(logic [1:0] k, logic [31:0] s, logic [31:0] l,
                                logic known, logic [2:0] st, logic [31:0] a,
                                logic rm);
        t_dir_row d;
        d.req = '{req_type: k, start_page: s, num_pages: l};
        d.known = known;
        d.rsp = '{status: st, alloc_start: a, removed_any: rm};
        dir_tab[dir_cnt] = d;
        dir_cnt++;
    endfunction

    // ------------------------------------------------------------------
    // random request source, biased to keep the table small and overlapping
    // ------------------------------------------------------------------
    int fill_left, split_left, wipe_left;

    function automatic logic [31:0] pick_start();
        int i, r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 4000);
        if (r < 80) return $urandom;
        if (r < 90) return 32'hFFFF_FF00 | $urandom_range(0, 255);
        for (i = 0; i < ENTRIES; i++)
            if (free_vld[i]) return free_start[i];
        return $urandom_range(0, 4000);
    endfunction

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15) return $urandom;
        return $urandom_range(1, 300);
    endfunction

    function automatic t_req next_request();
        t_req r;
        int   i, roll;
        r = '0;
        if (fill_left > 0) begin
            fill_left--;
            r.req_type = REQ_ADD;
            r.start_page = 32'h0010_0000 + fill_left * 4096;
            r.num_pages = $urandom_range(8, 2000);
            return r;
        end
        if (split_left > 0) begin
            // cut a hole in one range of a packed table so it would overflow
            split_left--;
            r.req_type = REQ_REMOVE;
            r.start_page = 32'h0000_1000;
            r.num_pages = 1;
            for (i = 0; i < ENTRIES; i++)
                if (free_vld[i] && free_len[i] >= 3 && free_start[i] != PAGE_NONE) begin
                    r.start_page = free_start[i] + 1;
                    break;
                end
            return r;
        end
        if (wipe_left > 0) begin
            wipe_left--;
            r.req_type = REQ_REMOVE;
            r.start_page = '0;
            r.num_pages = 32'hFFFF_FFFF;
            return r;
        end
        roll = $urandom_range(0, 99);
        if (roll < 40 && free_cnt < 14) begin
            r.req_type = REQ_ADD;
            r.start_page = pick_start();
            r.num_pages = pick_len();
            if ($urandom_range(0, 9) == 0)
                for (i = 0; i < ENTRIES; i++)
                    if (free_vld[i]) begin
                        r.start_page = free_start[i];
                        r.num_pages = free_len[i];
                        break;
                    end
        end else if (roll < 72) begin
            r.req_type = REQ_ALLOC;
            r.num_pages = pick_len();
            if ($urandom_range(0, 1) == 0)
                for (i = $urandom_range(0, ENTRIES - 1); i < ENTRIES; i++)
                    if (free_vld[i]) begin
                        r.num_pages = $urandom_range(1, 3) == 1 ? free_len[i]
                                    : $urandom_range(1, free_len[i] > 1000 ? 1000
                                                               : free_len[i]);
                        break;
                    end
        end else begin
            r.req_type = REQ_REMOVE;
            r.start_page = pick_start();
            r.num_pages = pick_len();
            for (i = $urandom_range(0, ENTRIES - 1); i < ENTRIES; i++)
                if (free_vld[i] && $urandom_range(0, 1) == 1) begin
                    r.start_page = free_start[i] + $urandom_range(0, 40) - 20;
                    break;
                end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side: bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send(t_req r, logic known, t_rsp want);
        t_rsp got;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        got = apply_request(r);
        rsp_mem[rsp_wr % RSP_DEPTH] = known ? want : got;
        rsp_wr++;
        req_cnt[r.req_type]++;
    endtask

    int burst_left;

    task automatic maybe_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        err_cnt = 0;
        full_cnt = 0; fit_cnt = 0; removed_cnt = 0;
        hold_req = 0; burst_left = 0;
        fill_left = 0; split_left = 0; wipe_left = 0;
        rsp_wr = 0; rsp_rd = 0; dir_cnt = 0;
        foreach (req_cnt[i]) req_cnt[i] = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            free_vld[i] = 1'b0; free_start[i] = '0; free_len[i] = '0;
        end
        free_cnt = 0;

        row(REQ_ADD,    32'd100,        32'd0,          1, ST_INVALID, 0, 0);
        row(REQ_ADD,    32'd100,        32'd50,         1, ST_OK,      0, 0);
        row(REQ_ADD,    32'd100,        32'd50,         1, ST_DUP,     0, 0);
        row(REQ_ALLOC,  32'd0,          32'd0,          1, ST_NOFIT,   0, 0);
        row(REQ_ALLOC,  32'd0,          32'd51,         1, ST_NOFIT,   0, 0);
        row(REQ_ALLOC,  32'hFFFF_FFFF,  32'd10,         1, ST_OK,      100, 0);
        row(REQ_REMOVE, 32'hFFFF_FFFF,  32'd5,          1, ST_INVALID, 0, 0);
        row(REQ_REMOVE, 32'd5,          32'd0,          1, ST_INVALID, 0, 0);
        row(REQ_BAD,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, ST_INVALID, 0, 0);
        row(REQ_ADD,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  0, ST_OK,      0, 0);
        row(REQ_ADD,    32'd0,          32'hFFFF_FFFF,  0, ST_OK,      0, 0);
        row(REQ_REMOVE, 32'd120,        32'd10,         0, ST_OK,      0, 0);
        row(REQ_ALLOC,  32'd0,          32'hFFFF_FFFF,  0, ST_OK,      0, 0);
        row(REQ_ADD,    32'hFFFF_FFF0,  32'd100,        0, ST_OK,      0, 0);
        row(REQ_ALLOC,  32'd0,          32'd100,        0, ST_OK,      0, 0);
        row(REQ_REMOVE, 32'hFFFF_FFFE,  32'hFFFF_FFFF,  0, ST_OK,      0, 0);
        row(REQ_ADD,    32'd200,        32'd20,         0, ST_OK,      0, 0);
        row(REQ_ADD,    32'd200,        32'd10,         0, ST_OK,      0, 0);
        row(REQ_ALLOC,  32'd0,          32'd10,         0, ST_OK,      0, 0);
        row(REQ_REMOVE, 32'd205,        32'd3,          0, ST_OK,      0, 0);
        row(REQ_REMOVE, 32'd0,          32'hFFFF_FFFF,  0, ST_OK,      0, 0);
        row(REQ_ALLOC,  32'd0,          32'd1,          1, ST_NOFIT,   0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < dir_cnt; i++) begin
            maybe_gap();
            send(dir_tab[i].req, dir_tab[i].known, dir_tab[i].rsp);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // fill to the top, overflow with a split, then wipe everything
            if (n == 300 || n == 1200) begin
                fill_left = 70; split_left = 2; wipe_left = 1;
            end
            if (n == 600)
                hold_req++;
            if (n == 900) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (rsp_wr != rsp_rd);
            end
            maybe_gap();
            send(next_request(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (rsp_wr != rsp_rd);
        repeat (200) @(posedge i_clk);

        $display("covered add %0d, allocate %0d, remove %0d, unknown %0d requests",
                 req_cnt[REQ_ADD], req_cnt[REQ_ALLOC], req_cnt[REQ_REMOVE],
                 req_cnt[REQ_BAD]);
        $display("fits %0d, removes that took pages %0d, table full %0d",
                 fit_cnt, removed_cnt, full_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: stall pattern that changes mode, plus one long hold-off
    // ------------------------------------------------------------------
    int   stall_mode, mode_left, hold_left, hold_seen;
    t_rsp want;

    initial begin
        stall_mode = 0; mode_left = 0; hold_left = 0; hold_seen = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_wr == rsp_rd) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected response transfer %p", o_out_data);
            end else begin
                want = rsp_mem[rsp_rd % RSP_DEPTH];
                rsp_rd++;
                if (o_out_data.status != want.status ||
                    o_out_data.alloc_start != want.alloc_start ||
                    o_out_data.removed_any != want.removed_any) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
                                 want.status, want.alloc_start, want.removed_any,
                                 o_out_data.status, o_out_data.alloc_start,
                                 o_out_data.removed_any);
                end
                if (want.status == ST_FULL) full_cnt++;
                if (want.status == ST_OK && want.alloc_start != 0) fit_cnt++;
                if (want.removed_any) removed_cnt++;
            end
        end

        // next stall value
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= $urandom_range(0, 3) == 0;
                2: i_out_stall <= $urandom_range(0, 3) != 0;
                default: i_out_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // run time guard
    // ------------------------------------------------------------------
    int cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout, %0d responses outstanding", rsp_wr - rsp_rd);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/fpra_pkg.sv
design/fpra_unit.sv
design/free_page_range_allocator.sv
bench/tb_free_page_range_allocator.sv
